### rtl/gded_pkg.sv
// Shared types and codes for the group debounce edge detector.
package gded_pkg;

    localparam int LEVELS_W = 16;
    localparam int STATUS_W = 48;
    localparam int TICK_W   = 32;
    localparam int CFG_W    = 32;
    localparam int PHASE_W  = 2;
    localparam int CODE_W   = 3;

    // Configuration register indexes
    localparam logic [0:0] REG_DEBOUNCE_TICKS  = 1'b0;
    localparam logic [0:0] REG_PIN_ENABLE_MASK = 1'b1;

    // Per-pin status codes
    localparam logic [CODE_W-1:0] CODE_LOW     = 3'd0;
    localparam logic [CODE_W-1:0] CODE_HIGH    = 3'd1;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 3'd2;
    localparam logic [CODE_W-1:0] CODE_FALLING = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RISING  = 3'd4;

    // Phase codes as reported on the result channel
    localparam logic [PHASE_W-1:0] PHASE_CODE_CHECK  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_WAIT   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_UPDATE = 2'd2;

    typedef enum logic [2:0] {
        PH_CHECK  = 3'b001,
        PH_WAIT   = 3'b010,
        PH_UPDATE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] pin_status;
        logic [PHASE_W-1:0]  phase;
    } gded_result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_WAIT:   code = PHASE_CODE_WAIT;
            PH_UPDATE: code = PHASE_CODE_UPDATE;
            default:   code = PHASE_CODE_CHECK;
        endcase
        return code;
    endfunction

endpackage

### rtl/gded_step.sv
// Debounce state registers and the combinational step logic for one item.
module gded_step
    import gded_pkg::*;
#(
    parameter int NUM_PINS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                kind,
    input  logic [TICK_W-1:0]   now_tick,
    input  logic [LEVELS_W-1:0] pin_levels,
    input  logic [TICK_W-1:0]   debounce_ticks,
    input  logic [LEVELS_W-1:0] pin_enable_mask,
    output gded_result_t        result
);

    // Only pins that have both a level bit and an enable bit can take part
    localparam int ACT = (NUM_PINS < LEVELS_W) ? NUM_PINS : LEVELS_W;

    logic [ACT-1:0]        ref_reg, ref_next;
    logic [3*ACT-1:0]      status_codes_reg, status_codes_next;
    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     start_tick_reg, start_tick_next;

    logic [ACT-1:0]        lv;
    logic [ACT-1:0]        en;
    logic [ACT-1:0]        diff;
    logic [TICK_W-1:0]     elapsed;
    logic [STATUS_W-1:0]   visible;

    assign lv      = pin_levels[ACT-1:0];
    assign en      = pin_enable_mask[ACT-1:0];
    assign diff    = (lv ^ ref_reg) & en;
    assign elapsed = now_tick - start_tick_reg;

    always_comb
    begin
        ref_next          = ref_reg;
        status_codes_next = status_codes_reg;
        phase_next        = phase_reg;
        start_tick_next   = start_tick_reg;
        if (kind)
        begin
            ref_next          = lv;
            start_tick_next   = now_tick;
            status_codes_next = '0;
            phase_next        = PH_CHECK;
        end
        else
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (elapsed >= debounce_ticks)
                        phase_next = PH_UPDATE;
                end
                PH_UPDATE:
                begin
                    for (int i = 0; i < ACT; i++)
                    begin
                        if (diff[i])
                            status_codes_next[3*i +: 3] = lv[i] ? CODE_RISING : CODE_FALLING;
                    end
                    ref_next        = (ref_reg & ~en) | (lv & en);
                    start_tick_next = now_tick;
                    phase_next      = PH_CHECK;
                end
                default:
                begin
                    for (int i = 0; i < ACT; i++)
                    begin
                        if (en[i])
                        begin
                            if (diff[i])
                                status_codes_next[3*i +: 3] = CODE_UNKNOWN;
                            else
                                status_codes_next[3*i +: 3] = lv[i] ? CODE_HIGH : CODE_LOW;
                        end
                    end
                    phase_next = (|diff) ? PH_WAIT : PH_CHECK;
                end
            endcase
        end
    end

    // Disabled pins read as low
    always_comb
    begin
        visible = '0;
        for (int i = 0; i < ACT; i++)
        begin
            if (en[i])
                visible[3*i +: 3] = status_codes_next[3*i +: 3];
        end
    end

    assign result.pin_status = visible;
    assign result.phase      = phase_code(phase_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg          <= '0;
            status_codes_reg <= '0;
            phase_reg        <= PH_CHECK;
            start_tick_reg   <= '0;
        end
        else if (fire)
        begin
            ref_reg          <= ref_next;
            status_codes_reg <= status_codes_next;
            phase_reg        <= phase_next;
            start_tick_reg   <= start_tick_next;
        end
    end

`ifndef SYNTHESIS
    a_capture_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && kind |=> phase_reg == PH_CHECK && start_tick_reg == $past(now_tick)
                         && status_codes_reg == '0)
        else $error("capture did not restart the debounce state");

    a_update_returns: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !kind && phase_reg == PH_UPDATE
            |=> phase_reg == PH_CHECK && start_tick_reg == $past(now_tick))
        else $error("update phase did not return to check with a new start tick");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(ref_reg) && $stable(start_tick_reg))
        else $error("debounce state moved without a transfer");
`endif

endmodule

### rtl/gded_obuf.sv
// Two-entry result buffer: output register plus skid register.
module gded_obuf
    import gded_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  gded_result_t push_data,
    output logic         full,
    output logic         result_valid,
    input  logic         result_stall,
    output gded_result_t result_data
);

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    gded_result_t out_data_reg, out_data_next;
    gded_result_t skid_data_reg, skid_data_next;
    logic         out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register is empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && result_stall && push))
        else $error("skid register filled without a stalled output");
`endif

endmodule

### rtl/group_debounce_edge_detector_top.sv
// Top level of the group debounce edge detector: config registers, step logic, result buffer.
//
// Usage:
//   Item channel (item_valid / item_stall) carries kind, now_tick and pin_levels.
//   kind = 1 captures the reference levels and the start tick; kind = 0 runs one
//   step of the check / wait / update sequence on the sampled pin vector.
//   Result channel (result_valid / result_stall) returns one pin_status and phase
//   per item, 3 status bits per pin, disabled pins reading zero.
//   Config port: cfg_wr_en writes cfg_data into the register picked by cfg_index
//   (0 debounce_ticks, 1 pin_enable_mask); write only while the block is idle.
// Timing:
//   Every item is handled in the cycle of its transfer; the result goes to the output
//   register, or to the skid register under stall. One item per cycle is accepted while
//   item_stall is low; the step logic is a pin vector, a 32-bit tick subtract and a compare.
// Reset:
//   rst_n clears the phase to check, the reference levels, status codes, start
//   tick and both config registers, and empties the result buffer.
// Stall:
//   A stalled result holds in the output register; one more item is taken into
//   the skid register, after which item_stall rises until the result drains.
module group_debounce_edge_detector_top
    import gded_pkg::*;
#(
    parameter int NUM_PINS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                kind,
    input  logic [TICK_W-1:0]   now_tick,
    input  logic [LEVELS_W-1:0] pin_levels,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output logic [STATUS_W-1:0] pin_status,
    output logic [PHASE_W-1:0]  phase,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [TICK_W-1:0]   debounce_ticks_reg;
    logic [LEVELS_W-1:0] pin_enable_mask_reg;
    logic                item_fire;
    logic                buf_full;
    gded_result_t        step_result;
    gded_result_t        out_result;

    // Config writes land directly; no handshake, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg  <= '0;
            pin_enable_mask_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS:  debounce_ticks_reg  <= cfg_data[TICK_W-1:0];
                REG_PIN_ENABLE_MASK: pin_enable_mask_reg <= cfg_data[LEVELS_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold off new items only when both buffer entries are occupied
    assign item_stall = buf_full;
    assign item_fire  = item_valid && !buf_full;

    gded_step #(
        .NUM_PINS (NUM_PINS)
    ) u_step (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (item_fire),
        .kind            (kind),
        .now_tick        (now_tick),
        .pin_levels      (pin_levels),
        .debounce_ticks  (debounce_ticks_reg),
        .pin_enable_mask (pin_enable_mask_reg),
        .result          (step_result)
    );

    // Register the result of each transfer; absorb one extra under stall
    gded_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (item_fire),
        .push_data    (step_result),
        .full         (buf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (out_result)
    );

    assign pin_status = out_result.pin_status;
    assign phase      = out_result.phase;

`ifndef SYNTHESIS
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("item channel stalled with no result pending");

    a_phase_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> phase != 2'd3)
        else $error("result carries an unused phase code");

    a_capture_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire && kind && !result_valid |=> result_valid && pin_status == '0
                                               && phase == PHASE_CODE_CHECK)
        else $error("capture result is not cleared");
`endif

endmodule

### verif/tb_top.sv
// Self-checking testbench for the group debounce edge detector.
`timescale 1ns / 100ps

module tb_top;
    import gded_pkg::*;

    // One transfer on the item channel
    typedef struct packed {
        logic                kind;
        logic [TICK_W-1:0]   tick;
        logic [LEVELS_W-1:0] levels;
    } pin_sample_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                item_valid = 1'b0;
    logic                item_stall;
    logic                kind = 1'b0;
    logic [TICK_W-1:0]   now_tick = '0;
    logic [LEVELS_W-1:0] pin_levels = '0;

    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [STATUS_W-1:0] pin_status;
    logic [PHASE_W-1:0]  phase;

    logic                cfg_wr_en = 1'b0;
    logic [0:0]          cfg_index = REG_DEBOUNCE_TICKS;
    logic [CFG_W-1:0]    cfg_data = '0;

    group_debounce_edge_detector_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .now_tick     (now_tick),
        .pin_levels   (pin_levels),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pin_status   (pin_status),
        .phase        (phase),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Samples waiting to be offered, and the results the block still owes us
    pin_sample_t  pending_samples[$];
    gded_result_t expected_status[$];
    int           err_count = 0;

    // ------------------------------------------------------------------
    // Debouncer model: mirrors the configuration and the block's state.
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]   cfg_debounce = '0;
    logic [LEVELS_W-1:0] cfg_enable = '0;

    logic [LEVELS_W-1:0] dbn_ref_levels = '0;
    logic [STATUS_W-1:0] dbn_codes = '0;
    logic [PHASE_W-1:0]  dbn_phase = PHASE_CODE_CHECK;
    logic [TICK_W-1:0]   dbn_start_tick = '0;

    // Advance the model by one transfer and return the status it reports
    function automatic gded_result_t step_debouncer(input pin_sample_t s);
        gded_result_t        res;
        logic                changed;
        logic [TICK_W-1:0]   elapsed;
        logic [STATUS_W-1:0] visible;
        changed = 1'b0;
        visible = '0;
        if (s.kind)
        begin
            // Capture: new reference, timer restart, codes cleared
            dbn_ref_levels = s.levels;
            dbn_start_tick = s.tick;
            dbn_codes      = '0;
            dbn_phase      = PHASE_CODE_CHECK;
        end
        else
        begin
            case (dbn_phase)
                PHASE_CODE_WAIT:
                begin
                    // Elapsed time wraps modulo 2^32
                    elapsed = s.tick - dbn_start_tick;
                    if (elapsed >= cfg_debounce)
                        dbn_phase = PHASE_CODE_UPDATE;
                end
                PHASE_CODE_UPDATE:
                begin
                    for (int i = 0; i < LEVELS_W; i++)
                    begin
                        if (cfg_enable[i])
                        begin
                            // Unchanged pins keep whatever code the check left
                            if (s.levels[i] != dbn_ref_levels[i])
                                dbn_codes[CODE_W*i +: CODE_W] =
                                    s.levels[i] ? CODE_RISING : CODE_FALLING;
                            dbn_ref_levels[i] = s.levels[i];
                        end
                    end
                    dbn_phase      = PHASE_CODE_CHECK;
                    dbn_start_tick = s.tick;
                end
                default:
                begin
                    for (int i = 0; i < LEVELS_W; i++)
                    begin
                        if (cfg_enable[i])
                        begin
                            if (s.levels[i] != dbn_ref_levels[i])
                            begin
                                dbn_codes[CODE_W*i +: CODE_W] = CODE_UNKNOWN;
                                changed = 1'b1;
                            end
                            else
                                dbn_codes[CODE_W*i +: CODE_W] =
                                    s.levels[i] ? CODE_HIGH : CODE_LOW;
                        end
                    end
                    dbn_phase = changed ? PHASE_CODE_WAIT : PHASE_CODE_CHECK;
                end
            endcase
        end
        // Disabled pins always read as zero
        for (int i = 0; i < LEVELS_W; i++)
        begin
            if (cfg_enable[i])
                visible[CODE_W*i +: CODE_W] = dbn_codes[CODE_W*i +: CODE_W];
        end
        res.pin_status = visible;
        res.phase      = dbn_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending samples in bursts with random gaps. Every
    // accepted transfer is run through the model right here, at the edge
    // where the block takes it.
    // ------------------------------------------------------------------
    int          burst_left = 1;
    int          gap_left = 0;
    pin_sample_t next_sample;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_status.push_back(step_debouncer({kind, now_tick, pin_levels}));

            // Payload may only move when nothing is offered or the offer was taken
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    next_sample = pending_samples.pop_front();
                    kind       <= next_sample.kind;
                    now_tick   <= next_sample.tick;
                    pin_levels <= next_sample.levels;
                    item_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        // End of burst: pick the next burst and the gap before it
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern switches mode every so often; once, after
    // enough results, hold off for a long stretch so the block backs up
    // and stalls its input while the driver keeps offering.
    // ------------------------------------------------------------------
    int         stall_mode = 0;
    int         mode_left = 40;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         taken_count = 0;
    logic [2:0] stall_phase = '0;
    logic       stall_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_mode  = 0;
            mode_left   = 40;
            taken_count = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                taken_count++;
            stall_phase = stall_phase + 3'd1;

            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (!hold_done && taken_count >= 200)
            begin
                hold_done  = 1'b1;
                hold_left  = 100;
                stall_next = 1'b1;
            end
            else
            begin
                case (stall_mode)
                    1:       stall_next = ($urandom_range(0, 3) == 0);
                    2:       stall_next = ($urandom_range(0, 3) != 0);
                    3:       stall_next = (stall_phase < 3'd3);
                    default: stall_next = 1'b0;
                endcase
            end

            if (mode_left <= 1)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 80);
            end
            else
                mode_left--;

            result_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every accepted result with the oldest expectation.
    // ------------------------------------------------------------------
    gded_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $display("%0t: unexpected result: expected none actual status %h phase %0d",
                         $time, pin_status, phase);
                err_count++;
            end
            else
            begin
                want = expected_status.pop_front();
                if (pin_status !== want.pin_status)
                begin
                    $display("%0t: pin_status mismatch: expected %h actual %h",
                             $time, want.pin_status, pin_status);
                    err_count++;
                end
                if (phase !== want.phase)
                begin
                    $display("%0t: phase mismatch: expected %0d actual %0d",
                             $time, want.phase, phase);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [TICK_W-1:0] gen_tick = 32'd1000;

    task automatic queue_sample(input logic k, input logic [TICK_W-1:0] t,
                                input logic [LEVELS_W-1:0] lv);
        pending_samples.push_back({k, t, lv});
    endtask

    // Write one register; the block is idle whenever this is called
    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_DEBOUNCE_TICKS)
            cfg_debounce = val;
        else
            cfg_enable = val[LEVELS_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every queued sample is taken and every result is back
    task automatic drain;
        while (pending_samples.size() != 0 || item_valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Mostly capture-led sequences with small tick steps and occasional pin
    // flips, so the check / wait / update loop is exercised; the rest is noise.
    task automatic queue_random_samples(input int count);
        int                  made;
        int                  seq_len;
        int                  step_max;
        logic [TICK_W-1:0]   t;
        logic [TICK_W-1:0]   cap_t;
        logic [LEVELS_W-1:0] lv;
        made     = 0;
        step_max = (cfg_debounce <= 32) ? int'(cfg_debounce) / 2 + 2 : 8;
        while (made < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_sample(1'($urandom_range(0, 1)), $urandom, LEVELS_W'($urandom));
                made++;
            end
            else
            begin
                t     = ($urandom_range(0, 3) == 0) ? $urandom : gen_tick;
                cap_t = t;
                lv    = LEVELS_W'($urandom);
                queue_sample(1'b1, t, lv);
                made++;
                seq_len = $urandom_range(4, 24);
                repeat (seq_len)
                begin
                    case ($urandom_range(0, 11))
                        0:       t = cap_t - 1;          // longest elapsed time since capture
                        1:       t = $urandom;
                        default: t = t + $urandom_range(0, step_max);
                    endcase
                    case ($urandom_range(0, 7))
                        0:       lv = lv ^ LEVELS_W'($urandom);
                        1, 2:    lv = lv ^ (16'h0001 << $urandom_range(0, LEVELS_W - 1));
                        default: lv = lv;
                    endcase
                    queue_sample(1'b0, t, lv);
                    made++;
                end
                gen_tick = t;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] rnd_debounce [6];
    logic [CFG_W-1:0] rnd_enable [6];

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full group, short debounce, wrap of the tick counter
        write_reg(REG_DEBOUNCE_TICKS, 32'd3);
        write_reg(REG_PIN_ENABLE_MASK, 32'h0000_FFFF);
        queue_sample(1'b1, 32'd100, 16'h0000);
        queue_sample(1'b0, 32'd101, 16'h0000);        // all low, stays in check
        queue_sample(1'b0, 32'd102, 16'hFFFF);        // all unknown, enter wait
        queue_sample(1'b0, 32'd102, 16'hFFFF);        // too early
        queue_sample(1'b0, 32'd103, 16'hFFFF);        // exactly the debounce time
        queue_sample(1'b0, 32'd104, 16'hFFFF);        // all rising
        queue_sample(1'b0, 32'd105, 16'hFFFF);        // all high
        queue_sample(1'b0, 32'd106, 16'h0000);
        queue_sample(1'b0, 32'd200, 16'h0000);
        queue_sample(1'b0, 32'd201, 16'hA5A5);        // only some pins actually fell
        queue_sample(1'b1, 32'hFFFF_FFFE, 16'h5A5A);
        queue_sample(1'b0, 32'hFFFF_FFFF, 16'h5A5B);  // glitch on pin 0
        queue_sample(1'b0, 32'h0000_0000, 16'h5A5B);  // elapsed 2 across the wrap
        queue_sample(1'b0, 32'h0000_0001, 16'h5A5B);
        queue_sample(1'b0, 32'h0000_0002, 16'h5A5A);  // glitch gone at update time
        queue_sample(1'b0, 32'h0000_0003, 16'h0001);  // enter wait, then capture over it
        queue_sample(1'b1, 32'h0000_000A, 16'h0001);
        queue_sample(1'b0, 32'h0000_000B, 16'h0001);
        drain;

        // Directed: partial group, zero debounce
        write_reg(REG_DEBOUNCE_TICKS, 32'd0);
        write_reg(REG_PIN_ENABLE_MASK, 32'h0000_00F0);
        queue_sample(1'b1, 32'd0, 16'h0000);
        queue_sample(1'b0, 32'd1, 16'hFF0F);          // only disabled pins moved
        queue_sample(1'b0, 32'd2, 16'h0010);
        queue_sample(1'b0, 32'd2, 16'h0010);          // zero debounce passes at once
        queue_sample(1'b0, 32'd3, 16'h0F1F);
        queue_sample(1'b0, 32'd4, 16'h00E0);
        drain;

        // Directed: largest debounce, reached only at the full wrap distance
        write_reg(REG_DEBOUNCE_TICKS, 32'hFFFF_FFFF);
        write_reg(REG_PIN_ENABLE_MASK, 32'h0000_FFFF);
        queue_sample(1'b1, 32'd50, 16'h0000);
        queue_sample(1'b0, 32'd51, 16'h0001);
        queue_sample(1'b0, 32'd48, 16'h0001);
        queue_sample(1'b0, 32'd49, 16'h0001);
        queue_sample(1'b0, 32'd60, 16'h0001);
        queue_sample(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        drain;

        // Random phases over a spread of settings, extremes included
        rnd_debounce[0] = 32'd0;
        rnd_enable[0]   = 32'h0000_FFFF;
        rnd_debounce[1] = $urandom_range(1, 16);
        rnd_enable[1]   = $urandom_range(0, 16'hFFFF);
        rnd_debounce[2] = $urandom;
        rnd_enable[2]   = 32'h0000_FFFF;
        rnd_debounce[3] = 32'hFFFF_FFFF;
        rnd_enable[3]   = $urandom_range(0, 16'hFFFF);
        rnd_debounce[4] = $urandom_range(1, 8);
        rnd_enable[4]   = 32'h0000_0000;
        rnd_debounce[5] = $urandom_range(1, 32);
        rnd_enable[5]   = 32'h0000_FFFF;
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_DEBOUNCE_TICKS, rnd_debounce[p]);
            write_reg(REG_PIN_ENABLE_MASK, rnd_enable[p]);
            queue_random_samples(65);
            drain;
        end

        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/gded_pkg.sv
rtl/gded_step.sv
rtl/gded_obuf.sv
rtl/group_debounce_edge_detector_top.sv
verif/tb_top.sv
